/* src/d2q9c_pkg.sv */
// shared types, constants and helpers for the d2q9 bgk node collide unit
// no dependencies; every other file refers to this package by scoped names
package d2q9c_pkg;

  localparam int FRAC_BITS = 28;
  localparam int BND_LAT   = 3;
  localparam int MOM_LAT   = 1;
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int PROD_LAT  = 1;
  localparam int LANE_LAT  = 8;
  localparam int PIPE_LAT  = BND_LAT + MOM_LAT + DIV_LAT + PROD_LAT + LANE_LAT;
  localparam int CFG_IDX_W = 1;

  localparam logic [29:0] RATE_RST = 30'd402653184;
  localparam logic signed [29:0] LID_RST = 30'sd75318694;

  localparam logic signed [63:0] HALF_Q64 = 64'sd134217728;
  localparam logic signed [47:0] ONE_Q48  = 48'sd268435456;
  localparam logic signed [31:0] Q_MAX    = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN    = 32'sh80000000;

  // floor(2^35 / 9) and the magnitude clamp 9 * 2^31 for the divide by nine
  localparam logic [31:0] RECIP9     = 32'd3817748707;
  localparam int          RECIP_SH   = 35;
  localparam logic [34:0] FEQ_A_MAX  = 35'd19327352832;

  typedef enum logic [2:0] {
    KIND_INTERIOR = 3'd0,
    KIND_BOTTOM   = 3'd1,
    KIND_LID      = 3'd2,
    KIND_LEFT     = 3'd3,
    KIND_RIGHT    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    WT_REST = 2'd0,
    WT_AXIS = 2'd1,
    WT_DIAG = 2'd2
  } wt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE = 1'b0,
    CFG_LID  = 1'b1
  } cfg_idx_t;

  typedef logic [8:0][31:0] dvec_t;

  typedef struct packed {
    logic [2:0]         node_kind;
    logic signed [31:0] dist_in_0;
    logic signed [31:0] dist_in_1;
    logic signed [31:0] dist_in_2;
    logic signed [31:0] dist_in_3;
    logic signed [31:0] dist_in_4;
    logic signed [31:0] dist_in_5;
    logic signed [31:0] dist_in_6;
    logic signed [31:0] dist_in_7;
    logic signed [31:0] dist_in_8;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] dist_out_0;
    logic signed [31:0] dist_out_1;
    logic signed [31:0] dist_out_2;
    logic signed [31:0] dist_out_3;
    logic signed [31:0] dist_out_4;
    logic signed [31:0] dist_out_5;
    logic signed [31:0] dist_out_6;
    logic signed [31:0] dist_out_7;
    logic signed [31:0] dist_out_8;
    logic signed [31:0] density;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
  } out_req_t;

  localparam logic signed [1:0] DIR_X [9] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0,
                                             2'sd1, -2'sd1, -2'sd1, 2'sd1};
  localparam logic signed [1:0] DIR_Y [9] = '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                             2'sd1, 2'sd1, -2'sd1, -2'sd1};
  localparam wt_t WT_SEL [9] = '{WT_REST, WT_AXIS, WT_AXIS, WT_AXIS, WT_AXIS,
                                 WT_DIAG, WT_DIAG, WT_DIAG, WT_DIAG};

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = Q_MAX;
    end else if (x < -64'sd2147483648) begin
      r = Q_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* src/d2q9c_bound.sv */
// boundary rule stages: lid density, lid momentum product, wall and lid copies
// depends on d2q9c_pkg
module d2q9c_bound (
  input  logic                  clk,
  input  logic                  en,
  input  d2q9c_pkg::in_req_t    din,
  input  logic signed [29:0]    lid,
  output d2q9c_pkg::dvec_t      f_o
);

  d2q9c_pkg::dvec_t   f_a_r, f_a_nxt, f_b_r, f_c_r, f_c_nxt;
  logic [2:0]         kind_a_r, kind_b_r;
  logic signed [31:0] rl_a_r, rl_a_nxt;
  logic signed [35:0] m_b_r, m_b_nxt;
  logic signed [63:0] rl_sum, m_prod;
  logic signed [39:0] t7, t8;

  always_comb begin
    f_a_nxt[0] = din.dist_in_0;
    f_a_nxt[1] = din.dist_in_1;
    f_a_nxt[2] = din.dist_in_2;
    f_a_nxt[3] = din.dist_in_3;
    f_a_nxt[4] = din.dist_in_4;
    f_a_nxt[5] = din.dist_in_5;
    f_a_nxt[6] = din.dist_in_6;
    f_a_nxt[7] = din.dist_in_7;
    f_a_nxt[8] = din.dist_in_8;
    rl_sum = 64'(din.dist_in_0) + 64'(din.dist_in_1) + 64'(din.dist_in_3)
           + 64'sd2 * (64'(din.dist_in_2) + 64'(din.dist_in_5) + 64'(din.dist_in_6));
    rl_a_nxt = d2q9c_pkg::sat32(rl_sum);
  end

  always_comb begin
    m_prod  = 64'(rl_a_r) * 64'(lid);
    m_b_nxt = 36'((m_prod + d2q9c_pkg::HALF_Q64) >>> d2q9c_pkg::FRAC_BITS);
  end

  always_comb begin
    t7 = 40'($signed(f_b_r[1])) - 40'($signed(f_b_r[3]))
       + 40'sd2 * 40'($signed(f_b_r[5])) - 40'(m_b_r);
    t8 = 40'($signed(f_b_r[3])) - 40'($signed(f_b_r[1])) + 40'(m_b_r);
    f_c_nxt = f_b_r;
    case (kind_b_r)
      d2q9c_pkg::KIND_BOTTOM: begin
        f_c_nxt[2] = f_b_r[4];
        f_c_nxt[5] = f_b_r[7];
        f_c_nxt[6] = f_b_r[8];
      end
      d2q9c_pkg::KIND_LEFT: begin
        f_c_nxt[1] = f_b_r[3];
        f_c_nxt[5] = f_b_r[7];
        f_c_nxt[8] = f_b_r[6];
      end
      d2q9c_pkg::KIND_RIGHT: begin
        f_c_nxt[3] = f_b_r[1];
        f_c_nxt[6] = f_b_r[8];
        f_c_nxt[7] = f_b_r[5];
      end
      d2q9c_pkg::KIND_LID: begin
        f_c_nxt[4] = f_b_r[2];
        f_c_nxt[7] = d2q9c_pkg::sat32(64'(t7 >>> 1));
        f_c_nxt[8] = d2q9c_pkg::sat32(64'($signed(f_b_r[6])) + 64'(t8 >>> 1));
      end
      default: begin
        f_c_nxt = f_b_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_a_r    <= f_a_nxt;
      kind_a_r <= din.node_kind;
      rl_a_r   <= rl_a_nxt;
      f_b_r    <= f_a_r;
      kind_b_r <= kind_a_r;
      m_b_r    <= m_b_nxt;
      f_c_r    <= f_c_nxt;
    end
  end

  assign f_o = f_c_r;

endmodule

/* src/d2q9c_moment.sv */
// density and momentum sums for one node
// depends on d2q9c_pkg
module d2q9c_moment (
  input  logic                  clk,
  input  logic                  en,
  input  d2q9c_pkg::dvec_t      f_i,
  output d2q9c_pkg::dvec_t      f_o,
  output logic signed [31:0]    rho_o,
  output logic signed [35:0]    mx_o,
  output logic signed [35:0]    my_o
);

  d2q9c_pkg::dvec_t   f_r;
  logic signed [31:0] rho_r;
  logic signed [35:0] mx_r, my_r, sum, mx_nxt, my_nxt;
  logic signed [35:0] g [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      g[k] = 36'($signed(f_i[k]));
    end
    sum = ((g[0] + g[1]) + (g[2] + g[3])) + ((g[4] + g[5]) + (g[6] + g[7])) + g[8];
    mx_nxt = (g[1] - g[3]) + (g[5] - g[6]) + (g[8] - g[7]);
    my_nxt = (g[2] - g[4]) + (g[5] + g[6]) - (g[7] + g[8]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r   <= f_i;
      rho_r <= d2q9c_pkg::sat32(64'(sum));
      mx_r  <= mx_nxt;
      my_r  <= my_nxt;
    end
  end

  assign f_o   = f_r;
  assign rho_o = rho_r;
  assign mx_o  = mx_r;
  assign my_o  = my_r;

endmodule

/* src/d2q9c_div.sv */
// pipelined restoring divider: momentum * 2^28 / density, one quotient bit per stage
// depends on d2q9c_pkg
module d2q9c_div (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [35:0]    num,
  input  logic signed [31:0]    den,
  output logic signed [31:0]    quo
);

  localparam int NS = d2q9c_pkg::DIV_STEPS;

  logic [30:0] rem_r  [0:NS];
  logic [31:0] low_r  [0:NS];
  logic [31:0] q_r    [0:NS];
  logic [30:0] den_r  [0:NS];
  logic        neg_r  [0:NS];
  logic        ovf_r  [0:NS];
  logic        zero_r [0:NS];
  logic signed [31:0] quo_r, quo_nxt;

  logic        neg0, zero0, ovf0;
  logic [34:0] mag0;

  always_comb begin
    neg0  = num < 0;
    mag0  = neg0 ? 35'(-num) : 35'(num);
    zero0 = den <= 0;
    ovf0  = mag0 >= {den[30:0], 4'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= mag0[34:4];
      low_r[0]  <= {mag0[3:0], 28'd0};
      q_r[0]    <= '0;
      den_r[0]  <= den[30:0];
      neg_r[0]  <= neg0;
      ovf_r[0]  <= ovf0;
      zero_r[0] <= zero0;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_step
    logic [31:0] rem2;
    logic        ge;
    logic [31:0] diff;
    always_comb begin
      rem2 = {rem_r[s], low_r[s][31]};
      diff = rem2 - {1'b0, den_r[s]};
      ge   = rem2 >= {1'b0, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= ge ? diff[30:0] : rem2[30:0];
        low_r[s+1]  <= {low_r[s][30:0], 1'b0};
        q_r[s+1]    <= {q_r[s][30:0], ge};
        den_r[s+1]  <= den_r[s];
        neg_r[s+1]  <= neg_r[s];
        ovf_r[s+1]  <= ovf_r[s];
        zero_r[s+1] <= zero_r[s];
      end
    end
  end

  always_comb begin
    if (zero_r[NS]) begin
      quo_nxt = '0;
    end else if (ovf_r[NS] || q_r[NS][31]) begin
      quo_nxt = neg_r[NS] ? d2q9c_pkg::Q_MIN : d2q9c_pkg::Q_MAX;
    end else if (neg_r[NS]) begin
      quo_nxt = $signed(~q_r[NS] + 32'd1);
    end else begin
      quo_nxt = $signed(q_r[NS]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

/* src/d2q9c_lane.sv */
// one direction's equilibrium and relaxation pipeline
// depends on d2q9c_pkg
module d2q9c_lane (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [1:0]     dir_x,
  input  logic signed [1:0]     dir_y,
  input  d2q9c_pkg::wt_t        wsel,
  input  logic signed [31:0]    f,
  input  logic signed [31:0]    rho,
  input  logic signed [31:0]    ux,
  input  logic signed [31:0]    uy,
  input  logic signed [35:0]    uu,
  input  logic signed [35:0]    vv,
  input  logic signed [35:0]    uv,
  input  logic [29:0]           rate,
  output logic signed [31:0]    res
);

  logic signed [31:0] fp_r [1:7];
  logic signed [31:0] rho1_r;
  logic signed [47:0] poly_r, poly_nxt, eu, eusq, usq, sxx, syy, sxy;
  logic signed [19:0] ph;
  logic signed [63:0] p1_r, p2_r, rp_r, rp_nxt, x4;
  logic [63:0]        mag4;
  logic               neg4_r, neg5_r, neg4;
  logic [34:0]        a4_r, a5_r, a4;
  logic [66:0]        prod5_r;
  logic [31:0]        q0;
  logic [35:0]        r6;
  logic [32:0]        q6;
  logic signed [31:0] feq_r, feq_nxt;
  logic signed [32:0] diff;
  logic signed [63:0] prod7_r, prod7_nxt;
  logic signed [31:0] res_r;

  always_comb begin
    sxx = 48'(dir_x) * 48'(dir_x);
    syy = 48'(dir_y) * 48'(dir_y);
    sxy = 48'(dir_x) * 48'(dir_y);
    eu   = 48'(dir_x) * 48'(ux) + 48'(dir_y) * 48'(uy);
    eusq = sxx * 48'(uu) + syy * 48'(vv) + 48'sd2 * sxy * 48'(uv);
    usq  = 48'(uu) + 48'(vv);
    poly_nxt = d2q9c_pkg::ONE_Q48 + 48'sd3 * eu + ((48'sd9 * eusq - 48'sd3 * usq) >>> 1);
  end

  assign ph = 20'(poly_r >>> d2q9c_pkg::FRAC_BITS);

  assign rp_nxt = p1_r + ((p2_r + d2q9c_pkg::HALF_Q64) >>> d2q9c_pkg::FRAC_BITS);

  always_comb begin
    x4   = (wsel == d2q9c_pkg::WT_REST) ? (rp_r <<< 2) : rp_r;
    neg4 = x4 < 0;
    mag4 = neg4 ? 64'(-x4) : 64'(x4);
    if (wsel == d2q9c_pkg::WT_DIAG) begin
      mag4 = mag4 >> 2;
    end
    a4 = (mag4 > 64'(d2q9c_pkg::FEQ_A_MAX)) ? d2q9c_pkg::FEQ_A_MAX : mag4[34:0];
  end

  always_comb begin
    q0 = prod5_r[66:d2q9c_pkg::RECIP_SH];
    r6 = {1'b0, a5_r} - 36'(q0) * 36'd9;
    q6 = 33'(q0) + ((r6 >= 36'd9) ? 33'd1 : 33'd0);
    if (q6 >= 33'h080000000) begin
      feq_nxt = neg5_r ? d2q9c_pkg::Q_MIN : d2q9c_pkg::Q_MAX;
    end else if (neg5_r) begin
      feq_nxt = $signed(~q6[31:0] + 32'd1);
    end else begin
      feq_nxt = $signed(q6[31:0]);
    end
  end

  always_comb begin
    diff      = 33'(fp_r[6]) - 33'(feq_r);
    prod7_nxt = 64'($signed({1'b0, rate})) * 64'(diff);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fp_r[1] <= f;
      for (int i = 2; i <= 7; i++) begin
        fp_r[i] <= fp_r[i-1];
      end
      rho1_r  <= rho;
      poly_r  <= poly_nxt;
      p1_r    <= 64'(rho1_r) * 64'(ph);
      p2_r    <= 64'(rho1_r) * 64'($signed({1'b0, poly_r[27:0]}));
      rp_r    <= rp_nxt;
      neg4_r  <= neg4;
      a4_r    <= a4;
      prod5_r <= 67'(a4_r) * 67'(d2q9c_pkg::RECIP9);
      a5_r    <= a4_r;
      neg5_r  <= neg4_r;
      feq_r   <= feq_nxt;
      prod7_r <= prod7_nxt;
      res_r   <= d2q9c_pkg::sat32(64'(fp_r[7])
                 - ((prod7_r + d2q9c_pkg::HALF_Q64) >>> d2q9c_pkg::FRAC_BITS));
    end
  end

  assign res = res_r;

endmodule

/* src/d2q9_bgk_node_collide_unit.sv */
// top level of the d2q9 bgk node collide unit: config registers, stall control,
// velocity products and delay lines; uses d2q9c_pkg, bound, moment, div and lane
//
// One lattice node request is taken every cycle while in_stall is low, and its result
// leaves after passing 3 boundary stages, 1 moment stage, 34 divider stages, 1 velocity
// product stage and 8 equilibrium and relaxation stages. Most of the depth comes from
// the two velocity dividers, which resolve one quotient bit per stage over 32 stages.
// A stalled result freezes the whole pipeline in place; input stall is raised
// exactly while a finished result waits on out_stall. Configuration writes take
// effect at once and are meant for an idle unit.
module d2q9_bgk_node_collide_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  d2q9c_pkg::in_req_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output d2q9c_pkg::out_req_t                 out_data,
  input  logic                                cfg_we,
  input  logic [d2q9c_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [29:0]                         cfg_wdata
);

  localparam int DL = d2q9c_pkg::DIV_LAT;
  localparam int LL = d2q9c_pkg::LANE_LAT;
  localparam int PL = d2q9c_pkg::PIPE_LAT;

  logic                 pipe_en;
  logic [PL-1:0]        vld_r, vld_nxt;
  logic [29:0]          rate_r, rate_nxt;
  logic signed [29:0]   lid_r, lid_nxt;

  d2q9c_pkg::dvec_t     f_b, f_m;
  logic signed [31:0]   rho_m, ux_d, uy_d;
  logic signed [35:0]   mx_m, my_m;

  d2q9c_pkg::dvec_t     f_dly_r   [0:DL];
  logic signed [31:0]   rho_dly_r [0:DL];
  logic signed [31:0]   ux_p_r, uy_p_r;
  logic signed [35:0]   uu_p_r, vv_p_r, uv_p_r;
  logic signed [31:0]   rho_o_r [0:LL-1];
  logic signed [31:0]   ux_o_r  [0:LL-1];
  logic signed [31:0]   uy_o_r  [0:LL-1];
  logic signed [31:0]   res_w   [9];

  assign pipe_en   = !(out_valid && out_stall);
  assign in_stall  = !pipe_en;
  assign out_valid = vld_r[PL-1];
  assign vld_nxt   = {vld_r[PL-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    rate_nxt = rate_r;
    lid_nxt  = lid_r;
    if (cfg_we) begin
      case (cfg_index)
        d2q9c_pkg::CFG_RATE: rate_nxt = cfg_wdata;
        d2q9c_pkg::CFG_LID:  lid_nxt  = $signed(cfg_wdata);
        default: begin
          rate_nxt = rate_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= d2q9c_pkg::RATE_RST;
      lid_r  <= d2q9c_pkg::LID_RST;
    end else begin
      rate_r <= rate_nxt;
      lid_r  <= lid_nxt;
    end
  end

  d2q9c_bound u_bound (
    .clk (clk),
    .en  (pipe_en),
    .din (in_data),
    .lid (lid_r),
    .f_o (f_b)
  );

  d2q9c_moment u_moment (
    .clk   (clk),
    .en    (pipe_en),
    .f_i   (f_b),
    .f_o   (f_m),
    .rho_o (rho_m),
    .mx_o  (mx_m),
    .my_o  (my_m)
  );

  d2q9c_div u_div_x (
    .clk (clk),
    .en  (pipe_en),
    .num (mx_m),
    .den (rho_m),
    .quo (ux_d)
  );

  d2q9c_div u_div_y (
    .clk (clk),
    .en  (pipe_en),
    .num (my_m),
    .den (rho_m),
    .quo (uy_d)
  );

  // node data rides alongside the dividers
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      f_dly_r[0]   <= f_m;
      rho_dly_r[0] <= rho_m;
      for (int i = 1; i <= DL; i++) begin
        f_dly_r[i]   <= f_dly_r[i-1];
        rho_dly_r[i] <= rho_dly_r[i-1];
      end
      ux_p_r <= ux_d;
      uy_p_r <= uy_d;
      uu_p_r <= 36'((64'(ux_d) * 64'(ux_d) + d2q9c_pkg::HALF_Q64) >>> d2q9c_pkg::FRAC_BITS);
      vv_p_r <= 36'((64'(uy_d) * 64'(uy_d) + d2q9c_pkg::HALF_Q64) >>> d2q9c_pkg::FRAC_BITS);
      uv_p_r <= 36'((64'(ux_d) * 64'(uy_d) + d2q9c_pkg::HALF_Q64) >>> d2q9c_pkg::FRAC_BITS);
      rho_o_r[0] <= rho_dly_r[DL];
      ux_o_r[0]  <= ux_p_r;
      uy_o_r[0]  <= uy_p_r;
      for (int i = 1; i < LL; i++) begin
        rho_o_r[i] <= rho_o_r[i-1];
        ux_o_r[i]  <= ux_o_r[i-1];
        uy_o_r[i]  <= uy_o_r[i-1];
      end
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_lane
    d2q9c_lane u_lane (
      .clk   (clk),
      .en    (pipe_en),
      .dir_x (d2q9c_pkg::DIR_X[k]),
      .dir_y (d2q9c_pkg::DIR_Y[k]),
      .wsel  (d2q9c_pkg::WT_SEL[k]),
      .f     ($signed(f_dly_r[DL][k])),
      .rho   (rho_dly_r[DL]),
      .ux    (ux_p_r),
      .uy    (uy_p_r),
      .uu    (uu_p_r),
      .vv    (vv_p_r),
      .uv    (uv_p_r),
      .rate  (rate_r),
      .res   (res_w[k])
    );
  end

  always_comb begin
    out_data.dist_out_0 = res_w[0];
    out_data.dist_out_1 = res_w[1];
    out_data.dist_out_2 = res_w[2];
    out_data.dist_out_3 = res_w[3];
    out_data.dist_out_4 = res_w[4];
    out_data.dist_out_5 = res_w[5];
    out_data.dist_out_6 = res_w[6];
    out_data.dist_out_7 = res_w[7];
    out_data.dist_out_8 = res_w[8];
    out_data.density    = rho_o_r[LL-1];
    out_data.velocity_x = ux_o_r[LL-1];
    out_data.velocity_y = uy_o_r[LL-1];
  end

  a_vel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.density <= 0) |->
      (out_data.velocity_x == 0) && (out_data.velocity_y == 0))
    else $error("velocity not zero for non-positive density");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("pipeline not empty after reset");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(vld_r))
    else $error("pipeline moved during output stall");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted request not tracked");

endmodule

/* dv/d2q9_bgk_node_collide_unit_tb.sv */
// testbench for the d2q9 bgk node collide unit: directed and random node requests,
// predicted in a scoreboard class and checked field by field; depends on d2q9c_pkg
`timescale 1ns / 100ps

module d2q9_bgk_node_collide_unit_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  d2q9c_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  d2q9c_pkg::out_req_t out_data;
  logic cfg_we = 1'b0;
  logic [d2q9c_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [29:0] cfg_wdata = '0;

  int errors = 0;
  bit calm = 1'b0;

  d2q9_bgk_node_collide_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report(input string what, input int idx, input logic [31:0] got,
                        input logic [31:0] want);
    $display("mismatch %s[%0d] got %h want %h at %0t", what, idx, got, want, $realtime);
    errors++;
  endtask

  class collide_scoreboard;
    longint rate;
    longint lid;
    d2q9c_pkg::out_req_t pending[$];

    function new();
      rate = d2q9c_pkg::RATE_RST;
      lid = longint'(d2q9c_pkg::LID_RST);
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint qmul(longint a, longint b);
      return (a * b + 134217728) >>> 28;
    endfunction

    function void write_reg(d2q9c_pkg::cfg_idx_t idx, logic [29:0] v);
      if (idx == d2q9c_pkg::CFG_RATE) rate = longint'({34'd0, v});
      else lid = longint'(signed'(v));
    endfunction

    function void note_request(d2q9c_pkg::in_req_t r);
      longint f[9], ex[9], ey[9], wn[9], wd[9];
      longint rl, m, sum, mx, my, rho, ux, uy, uu, vv, uv, usq;
      longint eu, eusq, poly, ph, pl, rp, feq, res;
      logic [31:0] o[12];
      d2q9c_pkg::out_req_t e;
      ex = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
      ey = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
      wn = '{4, 1, 1, 1, 1, 1, 1, 1, 1};
      wd = '{9, 9, 9, 9, 9, 36, 36, 36, 36};
      f = '{r.dist_in_0, r.dist_in_1, r.dist_in_2, r.dist_in_3, r.dist_in_4,
            r.dist_in_5, r.dist_in_6, r.dist_in_7, r.dist_in_8};
      case (r.node_kind)
        d2q9c_pkg::KIND_BOTTOM: begin
          f[2] = f[4]; f[5] = f[7]; f[6] = f[8];
        end
        d2q9c_pkg::KIND_LEFT: begin
          f[1] = f[3]; f[5] = f[7]; f[8] = f[6];
        end
        d2q9c_pkg::KIND_RIGHT: begin
          f[3] = f[1]; f[6] = f[8]; f[7] = f[5];
        end
        d2q9c_pkg::KIND_LID: begin
          rl = clamp32(f[0] + f[1] + f[3] + 2 * (f[2] + f[5] + f[6]));
          m = qmul(rl, lid);
          f[4] = f[2];
          f[7] = clamp32((f[1] - f[3] + 2 * f[5] - m) >>> 1);
          f[8] = clamp32(f[6] + ((f[3] - f[1] + m) >>> 1));
        end
        default: ;
      endcase
      sum = 0; mx = 0; my = 0;
      for (int k = 0; k < 9; k++) begin
        sum += f[k]; mx += ex[k] * f[k]; my += ey[k] * f[k];
      end
      rho = clamp32(sum);
      if (rho > 0) begin
        ux = clamp32((mx * 268435456) / rho);
        uy = clamp32((my * 268435456) / rho);
      end else begin
        ux = 0; uy = 0;
      end
      uu = qmul(ux, ux); vv = qmul(uy, uy); uv = qmul(ux, uy);
      usq = uu + vv;
      for (int k = 0; k < 9; k++) begin
        eu = ex[k] * ux + ey[k] * uy;
        eusq = ex[k] * ex[k] * uu + ey[k] * ey[k] * vv + 2 * ex[k] * ey[k] * uv;
        poly = 268435456 + 3 * eu + ((9 * eusq - 3 * usq) >>> 1);
        ph = poly >>> 28;
        pl = poly - ph * 268435456;
        rp = rho * ph + ((rho * pl + 134217728) >>> 28);
        feq = clamp32((wn[k] * rp) / wd[k]);
        res = clamp32(f[k] - qmul(rate, f[k] - feq));
        o[k] = res[31:0];
      end
      o[9] = rho[31:0]; o[10] = ux[31:0]; o[11] = uy[31:0];
      e = {o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8], o[9], o[10], o[11]};
      pending.push_back(e);
    endfunction

    task check_result(d2q9c_pkg::out_req_t got);
      d2q9c_pkg::out_req_t want;
      logic [11:0][31:0] g, w;
      if (pending.size() == 0) begin
        report("unexpected", 0, 32'd0, 32'd0);
        return;
      end
      want = pending.pop_front();
      g = got; w = want;
      for (int i = 0; i < 12; i++)
        if (g[11 - i] !== w[11 - i]) report("field", i, g[11 - i], w[11 - i]);
    endtask
  endclass

  collide_scoreboard sb = new();

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 29);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= idle_now();
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  task automatic write_cfg(d2q9c_pkg::cfg_idx_t idx, logic [29:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic send(d2q9c_pkg::in_req_t r);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (d2q9c_pkg::PIPE_LAT + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(3) == 0 ? 32'h7fffffff : 32'h80000000;
      default: return 32'($urandom_range(60000000, 0)) - 32'd10000000;
    endcase
  endfunction

  function automatic d2q9c_pkg::in_req_t rand_node(bit wild_kind);
    d2q9c_pkg::in_req_t r;
    r.node_kind = wild_kind ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    r.dist_in_0 = rand_q(); r.dist_in_1 = rand_q(); r.dist_in_2 = rand_q();
    r.dist_in_3 = rand_q(); r.dist_in_4 = rand_q(); r.dist_in_5 = rand_q();
    r.dist_in_6 = rand_q(); r.dist_in_7 = rand_q(); r.dist_in_8 = rand_q();
    return r;
  endfunction

  function automatic d2q9c_pkg::in_req_t flat_node(logic [2:0] kind, logic [31:0] v);
    return {kind, v, v, v, v, v, v, v, v, v};
  endfunction

  initial begin
    logic [29:0] rates[4], lids[4];
    rates = '{30'd0, 30'd536870912, 30'd268435456, 30'd402653184};
    lids = '{30'h30000000, 30'd268435456, 30'd0, 30'd75318694};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k < 8; k++) send(flat_node(3'(k), 32'd29826162));
    send(flat_node(d2q9c_pkg::KIND_INTERIOR, 32'h7fffffff));
    send(flat_node(d2q9c_pkg::KIND_LID, 32'h7fffffff));
    send(flat_node(d2q9c_pkg::KIND_INTERIOR, 32'h80000000));
    send(flat_node(d2q9c_pkg::KIND_LID, 32'h80000000));
    send(flat_node(d2q9c_pkg::KIND_INTERIOR, 32'd0));
    send(flat_node(d2q9c_pkg::KIND_INTERIOR, 32'hffffffff));
    send({d2q9c_pkg::KIND_INTERIOR, 32'd0, 32'h10000000, {7{32'd0}}});
    send({d2q9c_pkg::KIND_INTERIOR, 32'd0, 32'h7fffffff, {7{32'd0}}});
    send({d2q9c_pkg::KIND_INTERIOR, 32'd1, 32'h80000000, {7{32'd0}}});
    send({d2q9c_pkg::KIND_INTERIOR, 32'h80000000, {8{32'h7fffffff}}});
    for (int k = 0; k < 5; k++) send(rand_node(1'b1));
    drain();
    for (int p = 0; p < 4; p++) begin
      write_cfg(d2q9c_pkg::CFG_RATE, rates[p]);
      write_cfg(d2q9c_pkg::CFG_LID, lids[p]);
      for (int n = 0; n < 360; n++) begin
        calm = (p == 1) && (n >= 100) && (n < 220);
        send(rand_node(n % 10 == 0));
      end
      calm = 1'b0;
      drain();
    end
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
src/d2q9c_pkg.sv
src/d2q9c_bound.sv
src/d2q9c_moment.sv
src/d2q9c_div.sv
src/d2q9c_lane.sv
src/d2q9_bgk_node_collide_unit.sv
dv/d2q9_bgk_node_collide_unit_tb.sv
